// ===== sv/csh_pkg.sv =====
// Shared constants, codes and handshake structs for the call site histogram.
// No dependencies; used by the core, control and datapath files of the block.
`default_nettype none

package csh_pkg;

   localparam int SITES_DEF        = 64;
   localparam int CALLER_SLOTS_DEF = 16;

   localparam int KIND_W   = 2;
   localparam int SITE_W   = 6;
   localparam int ADDR_W   = 32;
   localparam int RSLOT_W  = 4;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 32;
   localparam int USED_W   = 5;
   localparam int HIT_W    = 4;
   localparam int INUSE_W  = 7;
   localparam int MASK_W   = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   localparam logic [KIND_W-1:0] KIND_CALL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_MATCHED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COUNT_ONLY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ       = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_SITES_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACKING_MASK = 1'b1;

   typedef struct packed {
      logic capture;
      logic load_read;
      logic load_scan;
      logic commit;
   } csh_cmd_type;

   typedef struct packed {
      logic out_free;
   } csh_stat_type;

endpackage

`default_nettype wire

// ===== sv/call_site_histogram_core.sv =====
// A request is captured on transfer, then passes the read, scan and update states;
// update waits while the response register holds an untaken response. No new request
// is taken until the read, compare, encode and write-back passes over the site row
// memories are done. A clear takes the same path and drops per-site valid flags.
// Reset: synchronous, active high; clears configuration, valid flags and handshake
// state at once, with no pass over the memories.
`default_nettype none

module call_site_histogram_core #(
   parameter int SITES        = csh_pkg::SITES_DEF,
   parameter int CALLER_SLOTS = csh_pkg::CALLER_SLOTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [csh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [csh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [csh_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [csh_pkg::SITE_W-1:0]      req_site_index,
   input  wire logic [csh_pkg::ADDR_W-1:0]      req_caller_address,
   input  wire logic [csh_pkg::RSLOT_W-1:0]     req_slot_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [csh_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [csh_pkg::CNT_W-1:0]       rsp_site_call_count,
   output logic      [csh_pkg::USED_W-1:0]      rsp_callers_used,
   output logic      [csh_pkg::HIT_W-1:0]       rsp_slot_hit,
   output logic      [csh_pkg::ADDR_W-1:0]      rsp_slot_address,
   output logic      [csh_pkg::CNT_W-1:0]       rsp_slot_count
);

   csh_pkg::csh_cmd_type  cmd;
   csh_pkg::csh_stat_type stat;

   csh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csh_dp #(
      .SITES        (SITES),
      .CALLER_SLOTS (CALLER_SLOTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_kind            (req_kind),
      .req_site_index      (req_site_index),
      .req_caller_address  (req_caller_address),
      .req_slot_index      (req_slot_index),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_site_call_count (rsp_site_call_count),
      .rsp_callers_used    (rsp_callers_used),
      .rsp_slot_hit        (rsp_slot_hit),
      .rsp_slot_address    (rsp_slot_address),
      .rsp_slot_count      (rsp_slot_count)
   );

endmodule

`default_nettype wire

// ===== sv/csh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/csh_ctrl.sv =====
// Sequencer for the call site histogram: capture, read, scan, update.
// Depends on csh_pkg for the command and status structs.
`default_nettype none

module csh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire csh_pkg::csh_stat_type stat,
   output csh_pkg::csh_cmd_type       cmd
);

   typedef enum logic [1:0] {
      IDLE,
      READ,
      SCAN,
      UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && req_ready_ff) begin
               state_in = READ;
            end
         end
         READ:   state_in = SCAN;
         SCAN:   state_in = UPDATE;
         UPDATE: begin
            if (stat.out_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      req_ready_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready     = req_ready_ff;
   assign cmd.capture   = (state_ff == IDLE) && req_valid && req_ready_ff;
   assign cmd.load_read = (state_ff == READ);
   assign cmd.load_scan = (state_ff == SCAN);
   assign cmd.commit    = (state_ff == UPDATE) && stat.out_free;

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("request side not reopened after commit");

endmodule

`default_nettype wire

// ===== sv/csh_dp.sv =====
// Datapath of the call site histogram: config registers, site and row memories,
// slot compare, priority encode, saturating update and response register.
// Depends on csh_pkg and csh_ram.
`default_nettype none

module csh_dp #(
   parameter int SITES        = csh_pkg::SITES_DEF,
   parameter int CALLER_SLOTS = csh_pkg::CALLER_SLOTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [csh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [csh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [csh_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [csh_pkg::SITE_W-1:0]      req_site_index,
   input  wire logic [csh_pkg::ADDR_W-1:0]      req_caller_address,
   input  wire logic [csh_pkg::RSLOT_W-1:0]     req_slot_index,
   input  wire csh_pkg::csh_cmd_type            cmd,
   output csh_pkg::csh_stat_type                stat,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [csh_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [csh_pkg::CNT_W-1:0]       rsp_site_call_count,
   output logic      [csh_pkg::USED_W-1:0]      rsp_callers_used,
   output logic      [csh_pkg::HIT_W-1:0]       rsp_slot_hit,
   output logic      [csh_pkg::ADDR_W-1:0]      rsp_slot_address,
   output logic      [csh_pkg::CNT_W-1:0]       rsp_slot_count
);

   localparam int SITE_AW = (SITES > 1) ? $clog2(SITES) : 1;
   localparam int SLOT_AW = (CALLER_SLOTS > 1) ? $clog2(CALLER_SLOTS) : 1;
   localparam int FILL_W  = $clog2(CALLER_SLOTS + 1);
   localparam int AW      = csh_pkg::ADDR_W;
   localparam int CW      = csh_pkg::CNT_W;
   localparam int ROW_W   = CALLER_SLOTS * AW;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // configuration
   logic [csh_pkg::INUSE_W-1:0] sites_in_use_ff, sites_in_use_in;
   logic [csh_pkg::MASK_W-1:0]  tracking_mask_ff, tracking_mask_in;

   // captured request
   logic [csh_pkg::KIND_W-1:0]  kind_ff;
   logic [csh_pkg::SITE_W-1:0]  site_ff;
   logic [AW-1:0]               caller_ff;
   logic [csh_pkg::RSLOT_W-1:0] rslot_ff;
   logic [SITE_AW-1:0]          site_addr;

   // per-site valid flags standing in for reset and clear of the site memories
   logic [SITES-1:0] cnt_valid_ff, cnt_valid_in;
   logic [SITES-1:0] fill_valid_ff, fill_valid_in;
   logic [SITES-1:0] in_use;

   // memory read data
   logic [CW-1:0]     cnt_rd;
   logic [FILL_W-1:0] fill_rd;
   logic [ROW_W-1:0]  addr_row_rd;
   logic [ROW_W-1:0]  cnt_row_rd;

   // read stage
   logic                    in_range;
   logic [CW-1:0]           cnt_cur;
   logic [FILL_W-1:0]       fill_cur;
   logic [CALLER_SLOTS-1:0] match_in;
   logic                    in_range_ff, tracked_ff;
   logic [CW-1:0]           cnt_ff;
   logic [FILL_W-1:0]       fill_ff;
   logic [CALLER_SLOTS-1:0] match_ff;

   // scan stage
   logic                          found;
   logic [SLOT_AW-1:0]            hit_idx;
   logic [csh_pkg::INUSE_W-1:0]   rslot_wide;
   logic [csh_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_AW-1:0]            sel_ff, sel_in;
   logic                          read_ok_ff, read_ok_in;

   // update stage
   logic [AW-1:0]                slot_addr_cur;
   logic [CW-1:0]                slot_cnt_cur;
   logic [CW-1:0]                cnt_new;
   logic [CW-1:0]                slot_cnt_new;
   logic [CW-1:0]                slot_cnt_wd;
   logic [FILL_W-1:0]            fill_plus;
   logic [csh_pkg::INUSE_W-1:0]  fill_wide;
   logic [csh_pkg::INUSE_W-1:0]  fill_plus_wide;
   logic [csh_pkg::INUSE_W-1:0]  sel_wide;
   logic                         call_done;
   logic                         cnt_we;
   logic                         fill_we;
   logic                         addr_row_we;
   logic                         cnt_row_we;
   logic [ROW_W-1:0]             addr_row_wd;
   logic [ROW_W-1:0]             cnt_row_wd;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [csh_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                 rsp_total_ff, rsp_total_in;
   logic [csh_pkg::USED_W-1:0]    rsp_used_ff, rsp_used_in;
   logic [csh_pkg::HIT_W-1:0]     rsp_hit_ff, rsp_hit_in;
   logic [AW-1:0]                 rsp_saddr_ff, rsp_saddr_in;
   logic [CW-1:0]                 rsp_scount_ff, rsp_scount_in;

   assign site_addr = site_ff[SITE_AW-1:0];

   always_comb begin
      sites_in_use_in  = sites_in_use_ff;
      tracking_mask_in = tracking_mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            csh_pkg::CSR_SITES_IN_USE:  sites_in_use_in  = csr_wdata[csh_pkg::INUSE_W-1:0];
            csh_pkg::CSR_TRACKING_MASK: tracking_mask_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      for (int s = 0; s < SITES; s++) begin
         in_use[s] = (csh_pkg::INUSE_W'(s) < sites_in_use_ff);
      end
   end

   csh_ram #(.WIDTH(CW), .DEPTH(SITES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (site_addr),
      .wr_data (cnt_new),
      .rd_en   (cmd.capture),
      .rd_addr (req_site_index[SITE_AW-1:0]),
      .rd_data (cnt_rd)
   );

   csh_ram #(.WIDTH(FILL_W), .DEPTH(SITES)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (site_addr),
      .wr_data (fill_plus),
      .rd_en   (cmd.capture),
      .rd_addr (req_site_index[SITE_AW-1:0]),
      .rd_data (fill_rd)
   );

   csh_ram #(.WIDTH(ROW_W), .DEPTH(SITES)) u_addr_row_ram (
      .clock   (clock),
      .wr_en   (addr_row_we),
      .wr_addr (site_addr),
      .wr_data (addr_row_wd),
      .rd_en   (cmd.capture),
      .rd_addr (req_site_index[SITE_AW-1:0]),
      .rd_data (addr_row_rd)
   );

   csh_ram #(.WIDTH(ROW_W), .DEPTH(SITES)) u_cnt_row_ram (
      .clock   (clock),
      .wr_en   (cnt_row_we),
      .wr_addr (site_addr),
      .wr_data (cnt_row_wd),
      .rd_en   (cmd.capture),
      .rd_addr (req_site_index[SITE_AW-1:0]),
      .rd_data (cnt_row_rd)
   );

   // read stage: unfilled slots never match
   always_comb begin
      in_range = ({1'b0, site_ff} < sites_in_use_ff) &&
                 ({1'b0, site_ff} < csh_pkg::INUSE_W'(SITES));
      cnt_cur  = (in_range && cnt_valid_ff[site_addr]) ? cnt_rd : '0;
      fill_cur = (in_range && fill_valid_ff[site_addr]) ? fill_rd : '0;
      for (int i = 0; i < CALLER_SLOTS; i++) begin
         match_in[i] = (kind_ff == csh_pkg::KIND_CALL) && (FILL_W'(i) < fill_cur) &&
                       (addr_row_rd[i*AW +: AW] == caller_ff);
      end
   end

   // scan stage: lowest matching slot wins
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = CALLER_SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found   = 1'b1;
            hit_idx = SLOT_AW'(i);
         end
      end
   end

   always_comb begin
      rslot_wide = csh_pkg::INUSE_W'(rslot_ff);
      status_in  = csh_pkg::ST_IGNORED;
      sel_in     = '0;
      read_ok_in = 1'b0;
      if (kind_ff == csh_pkg::KIND_CLEAR) begin
         status_in = csh_pkg::ST_CLEARED;
      end else if (in_range_ff && kind_ff == csh_pkg::KIND_READ) begin
         status_in  = csh_pkg::ST_READ;
         sel_in     = rslot_wide[SLOT_AW-1:0];
         read_ok_in = (rslot_wide < csh_pkg::INUSE_W'(CALLER_SLOTS)) &&
                      (rslot_wide < csh_pkg::INUSE_W'(fill_ff));
      end else if (in_range_ff && kind_ff == csh_pkg::KIND_CALL) begin
         if (!tracked_ff) begin
            status_in = csh_pkg::ST_COUNT_ONLY;
         end else if (found) begin
            status_in = csh_pkg::ST_MATCHED;
            sel_in    = hit_idx;
         end else if (fill_ff < FILL_W'(CALLER_SLOTS)) begin
            status_in = csh_pkg::ST_ADDED;
            sel_in    = fill_ff[SLOT_AW-1:0];
         end else begin
            status_in = csh_pkg::ST_DROPPED;
         end
      end
   end

   // update stage
   always_comb begin
      slot_addr_cur  = addr_row_rd[sel_ff*AW +: AW];
      slot_cnt_cur   = cnt_row_rd[sel_ff*CW +: CW];
      cnt_new        = sat_inc(cnt_ff);
      slot_cnt_new   = sat_inc(slot_cnt_cur);
      fill_plus      = fill_ff + 1'b1;
      fill_wide      = csh_pkg::INUSE_W'(fill_ff);
      fill_plus_wide = csh_pkg::INUSE_W'(fill_plus);
      sel_wide       = csh_pkg::INUSE_W'(sel_ff);
      slot_cnt_wd    = (status_ff == csh_pkg::ST_ADDED) ? CW'(1) : slot_cnt_new;

      call_done   = (status_ff == csh_pkg::ST_MATCHED) || (status_ff == csh_pkg::ST_ADDED) ||
                    (status_ff == csh_pkg::ST_DROPPED) ||
                    (status_ff == csh_pkg::ST_COUNT_ONLY);
      cnt_we      = cmd.commit && call_done;
      fill_we     = cmd.commit && (status_ff == csh_pkg::ST_ADDED);
      addr_row_we = fill_we;
      cnt_row_we  = cmd.commit && ((status_ff == csh_pkg::ST_ADDED) ||
                                   (status_ff == csh_pkg::ST_MATCHED));

      for (int i = 0; i < CALLER_SLOTS; i++) begin
         addr_row_wd[i*AW +: AW] = (SLOT_AW'(i) == sel_ff) ? caller_ff
                                                             : addr_row_rd[i*AW +: AW];
         cnt_row_wd[i*CW +: CW]  = (SLOT_AW'(i) == sel_ff) ? slot_cnt_wd
                                                             : cnt_row_rd[i*CW +: CW];
      end

      rsp_status_in = status_ff;
      rsp_total_in  = '0;
      rsp_used_in   = '0;
      rsp_hit_in    = '0;
      rsp_saddr_in  = '0;
      rsp_scount_in = '0;
      case (status_ff) inside
         csh_pkg::ST_MATCHED: begin
            rsp_total_in  = cnt_new;
            rsp_used_in   = fill_wide[csh_pkg::USED_W-1:0];
            rsp_hit_in    = sel_wide[csh_pkg::HIT_W-1:0];
            rsp_saddr_in  = caller_ff;
            rsp_scount_in = slot_cnt_new;
         end
         csh_pkg::ST_ADDED: begin
            rsp_total_in  = cnt_new;
            rsp_used_in   = fill_plus_wide[csh_pkg::USED_W-1:0];
            rsp_hit_in    = sel_wide[csh_pkg::HIT_W-1:0];
            rsp_saddr_in  = caller_ff;
            rsp_scount_in = CW'(1);
         end
         csh_pkg::ST_DROPPED, csh_pkg::ST_COUNT_ONLY: begin
            rsp_total_in = cnt_new;
            rsp_used_in  = fill_wide[csh_pkg::USED_W-1:0];
         end
         csh_pkg::ST_READ: begin
            rsp_total_in  = cnt_ff;
            rsp_used_in   = fill_wide[csh_pkg::USED_W-1:0];
            rsp_hit_in    = rslot_ff;
            rsp_saddr_in  = read_ok_ff ? slot_addr_cur : '0;
            rsp_scount_in = read_ok_ff ? slot_cnt_cur : '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cnt_valid_in  = cnt_valid_ff;
      fill_valid_in = fill_valid_ff;
      if (cmd.commit && status_ff == csh_pkg::ST_CLEARED) begin
         cnt_valid_in  = cnt_valid_ff & ~in_use;
         fill_valid_in = fill_valid_ff & ~(in_use & tracking_mask_ff[SITES-1:0]);
      end else begin
         if (cnt_we) begin
            cnt_valid_in[site_addr] = 1'b1;
         end
         if (fill_we) begin
            fill_valid_in[site_addr] = 1'b1;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sites_in_use_ff  <= '0;
         tracking_mask_ff <= '0;
         cnt_valid_ff     <= '0;
         fill_valid_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         sites_in_use_ff  <= sites_in_use_in;
         tracking_mask_ff <= tracking_mask_in;
         cnt_valid_ff     <= cnt_valid_in;
         fill_valid_ff    <= fill_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         site_ff   <= req_site_index;
         caller_ff <= req_caller_address;
         rslot_ff  <= req_slot_index;
      end
      if (cmd.load_read) begin
         in_range_ff <= in_range;
         tracked_ff  <= tracking_mask_ff[site_ff];
         cnt_ff      <= cnt_cur;
         fill_ff     <= fill_cur;
         match_ff    <= match_in;
      end
      if (cmd.load_scan) begin
         status_ff  <= status_in;
         sel_ff     <= sel_in;
         read_ok_ff <= read_ok_in;
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_saddr_ff  <= rsp_saddr_in;
         rsp_scount_ff <= rsp_scount_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_site_call_count = rsp_total_ff;
   assign rsp_callers_used    = rsp_used_ff;
   assign rsp_slot_hit        = rsp_hit_ff;
   assign rsp_slot_address    = rsp_saddr_ff;
   assign rsp_slot_count      = rsp_scount_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over an untaken response");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_scan |-> $onehot0(match_ff))
      else $error("caller address held in more than one slot");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status_ff == csh_pkg::ST_CLEARED) |=> ((cnt_valid_ff & in_use) == '0))
      else $error("site counter still live after clear");

   assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_plus <= FILL_W'(CALLER_SLOTS)))
      else $error("slot fill count beyond table size");

endmodule

`default_nettype wire
